// ===== sv/dwca_pkg.sv =====
// Shared types, register codes and constants of the disk window count argmax unit.
`timescale 1ns / 1ps
`default_nettype none
package dwca_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_MAP_WIDTH    = 2'd0;
    localparam logic [1:0] REG_MAP_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_REACH_MARKER = 2'd2;

    localparam logic [8:0]  MAP_WIDTH_RESET    = 9'd256;
    localparam logic [8:0]  MAP_HEIGHT_RESET   = 9'd256;
    localparam logic [7:0]  REACH_MARKER_RESET = 8'd30;
    localparam logic [12:0] COUNT_LIMIT        = 13'd8191;

    typedef struct packed {
        logic       start;
        logic [8:0] map_width;
        logic [8:0] map_height;
    } scan_req_t;

    typedef struct packed {
        logic loading;
        logic report_valid;
    } scan_stat_t;

    typedef struct packed {
        logic        found;
        logic [7:0]  best_row;
        logic [7:0]  best_column;
        logic [12:0] best_count;
        logic [12:0] best_free_count;
    } result_t;

    // Half width of the disk on the row that lies d rows from the center.
    function automatic int half_span(int d, int radius);
        int s;
        s = 0;
        while ((s + 1) * (s + 1) + d * d < radius * radius) begin
            s = s + 1;
        end
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== sv/dwca_ifs.sv =====
// Handshake interfaces for the cell words and the result words.
`timescale 1ns / 1ps
`default_nettype none
interface dwca_cell_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] known_value;
    logic signed [7:0] reachable_value;
    logic              last_cell;

    modport source (output valid, output known_value, output reachable_value,
                    output last_cell, input ready);
    modport sink   (input valid, input known_value, input reachable_value,
                    input last_cell, output ready);
endinterface

interface dwca_result_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [7:0]  best_row;
    logic [7:0]  best_column;
    logic [12:0] best_count;
    logic [12:0] best_free_count;

    modport source (output valid, output found, output best_row, output best_column,
                    output best_count, output best_free_count, input ready);
    modport sink   (input valid, input found, input best_row, input best_column,
                    input best_count, input best_free_count, output ready);
endinterface
`default_nettype wire

// ===== sv/dwca_cell_mem.sv =====
// Cell store: free and marked bit of every loaded cell, one write and one read port.
`timescale 1ns / 1ps
`default_nettype none
module dwca_cell_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [1:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [1:0]    rd_data
);
    logic [1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// ===== sv/dwca_prefix_mem.sv =====
// Row prefix store: marked bit and running marked count per cell, two read ports.
`timescale 1ns / 1ps
`default_nettype none
module dwca_prefix_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16,
    parameter int DW    = 10
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr_a,
    input  wire logic [AW-1:0] rd_addr_b,
    output logic      [DW-1:0] rd_data_a,
    output logic      [DW-1:0] rd_data_b
);
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end
endmodule
`default_nettype wire

// ===== sv/dwca_scan.sv =====
// Scan sequencer: builds the row prefix store, then sums each free cell's disk row by row.
`timescale 1ns / 1ps
`default_nettype none
module dwca_scan #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int RADIUS     = 40,
    parameter int AW         = 16,
    parameter int PVW        = 9
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dwca_pkg::scan_req_t req,
    output dwca_pkg::scan_stat_t     stat,
    output dwca_pkg::result_t        result,
    input  wire logic                res_take,
    output logic                     cell_rd_en,
    output logic [AW-1:0]            cell_rd_addr,
    input  wire logic [1:0]          cell_rd_data,
    output logic                     pref_wr_en,
    output logic [AW-1:0]            pref_wr_addr,
    output logic [PVW:0]             pref_wr_data,
    output logic                     pref_rd_en,
    output logic [AW-1:0]            pref_rd_addr_lo,
    output logic [AW-1:0]            pref_rd_addr_hi,
    input  wire logic [PVW:0]        pref_rd_data_lo,
    input  wire logic [PVW:0]        pref_rd_data_hi
);
    localparam int CLW   = $clog2(MAX_WIDTH + 1);
    localparam int RLW   = $clog2(MAX_HEIGHT + 1);
    localparam int SVW   = (RADIUS > 1) ? $clog2(RADIUS) : 1;
    localparam int KW    = $clog2(2 * RADIUS);
    localparam int SRW   = ((RLW > KW) ? RLW : KW) + 2;
    localparam int XW    = (CLW > SVW) ? CLW : SVW;
    localparam int CNW0  = $clog2((2 * RADIUS - 1) * (2 * RADIUS - 1) + 1);
    localparam int CNW   = (CNW0 > 13) ? CNW0 : 13;
    localparam int KLAST = 2 * RADIUS - 2;

    typedef enum logic [7:0] {
        S_LOAD     = 8'b0000_0001,
        S_PREFIX   = 8'b0000_0010,
        S_PDRAIN   = 8'b0000_0100,
        S_CELL_RD  = 8'b0000_1000,
        S_CELL_CHK = 8'b0001_0000,
        S_DISK     = 8'b0010_0000,
        S_DDRAIN   = 8'b0100_0000,
        S_REPORT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [RLW-1:0] r_reg, r_next;
    logic [CLW-1:0] c_reg, c_next;
    logic [AW-1:0]  p_reg, p_next;
    logic [KW-1:0]  k_reg, k_next;
    logic [AW-1:0]  base_reg, base_next;
    logic [CNW-1:0] total_reg, total_next;
    logic [CNW-1:0] mark_reg, mark_next;

    logic           v1_reg, first1_reg;
    logic [AW-1:0]  a1_reg;
    logic [PVW-1:0] acc_reg;
    logic           v2_reg;

    logic           found_reg, found_next;
    logic [RLW-1:0] brow_reg, brow_next;
    logic [CLW-1:0] bcol_reg, bcol_next;
    logic [CNW-1:0] bcnt_reg, bcnt_next;
    logic [CNW-1:0] bfree_reg, bfree_next;

    logic [CLW-1:0] w_eff;
    logic [RLW-1:0] h_eff;
    logic           grid_empty;
    logic           at_end;
    logic [PVW-1:0] acc_next;

    logic [SVW-1:0]        span_tab [RADIUS];
    logic signed [SRW-1:0] d_s, rr, ad_full;
    logic                  inb;
    logic [SVW-1:0]        s_val;
    logic [XW-1:0]         s_x, c_x, room_x, min_lo, min_hi;
    logic [CNW-1:0]        contrib, marked_fin;

    for (genvar gi = 0; gi < RADIUS; gi++)
    begin : g_span
        assign span_tab[gi] = SVW'(dwca_pkg::half_span(gi, RADIUS));
    end

    always_comb
    begin
        w_eff = (int'(req.map_width) > MAX_WIDTH) ? CLW'(MAX_WIDTH) : CLW'(req.map_width);
        h_eff = (int'(req.map_height) > MAX_HEIGHT) ? RLW'(MAX_HEIGHT)
                                                    : RLW'(req.map_height);
    end

    assign grid_empty = (w_eff == '0) || (h_eff == '0);
    assign at_end     = (c_reg == w_eff - CLW'(1)) && (r_reg == h_eff - RLW'(1));

    // Running marked count along the row; it restarts at column zero.
    assign acc_next = (first1_reg ? '0 : acc_reg) + PVW'(cell_rd_data[0]);

    // Disk row geometry for the current row offset.
    always_comb
    begin
        d_s     = $signed({{(SRW - KW){1'b0}}, k_reg}) - SRW'(RADIUS - 1);
        rr      = $signed({{(SRW - RLW){1'b0}}, r_reg}) + d_s;
        inb     = !rr[SRW-1] && (rr[SRW-2:0] < (SRW - 1)'(h_eff));
        ad_full = d_s[SRW-1] ? -d_s : d_s;
        s_val   = span_tab[ad_full[SVW-1:0]];
        s_x     = XW'(s_val);
        c_x     = XW'(c_reg);
        room_x  = XW'(w_eff - CLW'(1) - c_reg);
        min_lo  = (s_x < c_x) ? s_x : c_x;
        min_hi  = (s_x < room_x) ? s_x : room_x;
    end

    assign contrib = CNW'(pref_rd_data_hi[PVW-1:0]) - CNW'(pref_rd_data_lo[PVW-1:0])
                   + CNW'(pref_rd_data_lo[PVW]);
    assign marked_fin = mark_reg + (v2_reg ? contrib : '0);

    always_comb
    begin
        cell_rd_en      = 1'b0;
        cell_rd_addr    = p_reg;
        pref_rd_en      = 1'b0;
        pref_rd_addr_lo = base_reg - AW'(min_lo);
        pref_rd_addr_hi = base_reg + AW'(min_hi);
        state_next = state_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        p_next     = p_reg;
        k_next     = k_reg;
        base_next  = base_reg;
        total_next = total_reg;
        mark_next  = v2_reg ? marked_fin : mark_reg;
        found_next = found_reg;
        brow_next  = brow_reg;
        bcol_next  = bcol_reg;
        bcnt_next  = bcnt_reg;
        bfree_next = bfree_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                if (req.start)
                begin
                    found_next = 1'b0;
                    brow_next  = '0;
                    bcol_next  = '0;
                    bcnt_next  = '0;
                    bfree_next = '0;
                    r_next     = '0;
                    c_next     = '0;
                    p_next     = '0;
                    state_next = grid_empty ? S_REPORT : S_PREFIX;
                end
            end
            S_PREFIX:
            begin
                cell_rd_en = 1'b1;
                p_next     = p_reg + AW'(1);
                if (c_reg == w_eff - CLW'(1))
                begin
                    c_next = '0;
                    r_next = r_reg + RLW'(1);
                end
                else
                begin
                    c_next = c_reg + CLW'(1);
                end
                if (at_end)
                begin
                    state_next = S_PDRAIN;
                end
            end
            S_PDRAIN:
            begin
                r_next     = '0;
                c_next     = '0;
                p_next     = '0;
                state_next = S_CELL_RD;
            end
            S_CELL_RD:
            begin
                cell_rd_en = 1'b1;
                state_next = S_CELL_CHK;
            end
            S_CELL_CHK:
            begin
                if (cell_rd_data[1])
                begin
                    k_next     = '0;
                    base_next  = p_reg - AW'(AW'(RADIUS - 1) * AW'(w_eff));
                    total_next = '0;
                    mark_next  = '0;
                    state_next = S_DISK;
                end
                else
                begin
                    p_next = p_reg + AW'(1);
                    if (c_reg == w_eff - CLW'(1))
                    begin
                        c_next = '0;
                        r_next = r_reg + RLW'(1);
                    end
                    else
                    begin
                        c_next = c_reg + CLW'(1);
                    end
                    state_next = at_end ? S_REPORT : S_CELL_RD;
                end
            end
            S_DISK:
            begin
                pref_rd_en = inb;
                if (inb)
                begin
                    total_next = total_reg + CNW'(min_lo) + CNW'(min_hi) + CNW'(1);
                end
                base_next = base_reg + AW'(w_eff);
                k_next    = k_reg + KW'(1);
                if (k_reg == KW'(KLAST))
                begin
                    state_next = S_DDRAIN;
                end
            end
            S_DDRAIN:
            begin
                if (marked_fin > bcnt_reg)
                begin
                    found_next = 1'b1;
                    brow_next  = r_reg;
                    bcol_next  = c_reg;
                    bcnt_next  = marked_fin;
                    bfree_next = total_reg - marked_fin;
                end
                p_next = p_reg + AW'(1);
                if (c_reg == w_eff - CLW'(1))
                begin
                    c_next = '0;
                    r_next = r_reg + RLW'(1);
                end
                else
                begin
                    c_next = c_reg + CLW'(1);
                end
                state_next = at_end ? S_REPORT : S_CELL_RD;
            end
            S_REPORT:
            begin
                if (res_take)
                begin
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            found_reg <= 1'b0;
            brow_reg  <= '0;
            bcol_reg  <= '0;
            bcnt_reg  <= '0;
            bfree_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= (state_reg == S_PREFIX);
            v2_reg    <= (state_reg == S_DISK) && inb;
            found_reg <= found_next;
            brow_reg  <= brow_next;
            bcol_reg  <= bcol_next;
            bcnt_reg  <= bcnt_next;
            bfree_reg <= bfree_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg      <= r_next;
        c_reg      <= c_next;
        p_reg      <= p_next;
        k_reg      <= k_next;
        base_reg   <= base_next;
        total_reg  <= total_next;
        mark_reg   <= mark_next;
        a1_reg     <= p_reg;
        first1_reg <= (c_reg == '0);
        if (v1_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign pref_wr_en   = v1_reg;
    assign pref_wr_addr = a1_reg;
    assign pref_wr_data = {cell_rd_data[0], acc_next};

    assign stat.loading      = (state_reg == S_LOAD);
    assign stat.report_valid = (state_reg == S_REPORT);

    always_comb
    begin
        result.found           = found_reg;
        result.best_row        = 8'(brow_reg);
        result.best_column     = 8'(bcol_reg);
        result.best_count      = (bcnt_reg > CNW'(dwca_pkg::COUNT_LIMIT))
                               ? dwca_pkg::COUNT_LIMIT : 13'(bcnt_reg);
        result.best_free_count = (bfree_reg > CNW'(dwca_pkg::COUNT_LIMIT))
                               ? dwca_pkg::COUNT_LIMIT : 13'(bfree_reg);
    end
endmodule
`default_nettype wire

// ===== sv/disk_window_count_argmax_unit.sv =====
// Top level: configuration registers, cell loading, memories, scan and result register.
//
//  channel  | dir | handshake     | word
//  ---------+-----+---------------+-----------------------------------------------
//  cells    | in  | valid/ready   | known_value, reachable_value, last_cell
//  results  | out | valid/ready   | found, best_row, best_column, best_count,
//           |     |               | best_free_count
//  cfg      | in  | APB, pready=1 | map_width @0, map_height @4, reach_marker @8
//
// Cells load at one word per cycle into the cell store while the scan is idle.
// After the last cell the scan builds the row prefix store, then reads each cell and
// sums the disk of each free cell, one disk row per cycle on the two read ports of
// the prefix store.
// Reset clears control state only; the stores hold nothing valid until loaded.
// A waiting result stalls the return to loading, not the scan itself.
`timescale 1ns / 1ps
`default_nettype none
module disk_window_count_argmax_unit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int RADIUS     = 40
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    dwca_cell_if.sink                                cells,
    dwca_result_if.source                            results,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [dwca_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [dwca_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic      [dwca_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                     pready
);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = $clog2(DEPTH + 1);
    localparam int PVW   = $clog2(MAX_WIDTH + 1);

    logic [8:0] map_width_reg;
    logic [8:0] map_height_reg;
    logic [7:0] reach_marker_reg;
    logic [PW-1:0] pos_reg;

    logic cell_acc, cfg_wr;

    dwca_pkg::scan_req_t  req;
    dwca_pkg::scan_stat_t stat;
    dwca_pkg::result_t    res, out_reg;
    logic                 out_valid_reg, res_take;

    logic          cell_rd_en;
    logic [AW-1:0] cell_rd_addr;
    logic [1:0]    cell_rd_data;
    logic          pref_wr_en, pref_rd_en;
    logic [AW-1:0] pref_wr_addr, pref_rd_addr_lo, pref_rd_addr_hi;
    logic [PVW:0]  pref_wr_data, pref_rd_data_lo, pref_rd_data_hi;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg    <= dwca_pkg::MAP_WIDTH_RESET;
            map_height_reg   <= dwca_pkg::MAP_HEIGHT_RESET;
            reach_marker_reg <= dwca_pkg::REACH_MARKER_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                dwca_pkg::REG_MAP_WIDTH:    map_width_reg    <= pwdata[8:0];
                dwca_pkg::REG_MAP_HEIGHT:   map_height_reg   <= pwdata[8:0];
                dwca_pkg::REG_REACH_MARKER: reach_marker_reg <= pwdata[7:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            dwca_pkg::REG_MAP_WIDTH:    prdata = 32'(map_width_reg);
            dwca_pkg::REG_MAP_HEIGHT:   prdata = 32'(map_height_reg);
            dwca_pkg::REG_REACH_MARKER: prdata = 32'(reach_marker_reg);
            default:                    prdata = '0;
        endcase
    end

    assign cells.ready = stat.loading;
    assign cell_acc    = cells.valid && cells.ready;

    // Load position runs past the grid only up to the store depth, then holds.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (cell_acc)
        begin
            if (cells.last_cell)
            begin
                pos_reg <= '0;
            end
            else if (pos_reg < PW'(DEPTH))
            begin
                pos_reg <= pos_reg + PW'(1);
            end
        end
    end

    assign req.start      = cell_acc && cells.last_cell;
    assign req.map_width  = map_width_reg;
    assign req.map_height = map_height_reg;

    dwca_cell_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_cell_mem (
        .clk     (clk),
        .wr_en   (cell_acc && (pos_reg < PW'(DEPTH))),
        .wr_addr (pos_reg[AW-1:0]),
        .wr_data ({cells.known_value == 8'sd0,
                   cells.reachable_value == $signed(reach_marker_reg)}),
        .rd_en   (cell_rd_en),
        .rd_addr (cell_rd_addr),
        .rd_data (cell_rd_data)
    );

    dwca_prefix_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (PVW + 1)
    ) u_prefix_mem (
        .clk       (clk),
        .wr_en     (pref_wr_en),
        .wr_addr   (pref_wr_addr),
        .wr_data   (pref_wr_data),
        .rd_en     (pref_rd_en),
        .rd_addr_a (pref_rd_addr_lo),
        .rd_addr_b (pref_rd_addr_hi),
        .rd_data_a (pref_rd_data_lo),
        .rd_data_b (pref_rd_data_hi)
    );

    dwca_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .RADIUS     (RADIUS),
        .AW         (AW),
        .PVW        (PVW)
    ) u_scan (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req),
        .stat            (stat),
        .result          (res),
        .res_take        (res_take),
        .cell_rd_en      (cell_rd_en),
        .cell_rd_addr    (cell_rd_addr),
        .cell_rd_data    (cell_rd_data),
        .pref_wr_en      (pref_wr_en),
        .pref_wr_addr    (pref_wr_addr),
        .pref_wr_data    (pref_wr_data),
        .pref_rd_en      (pref_rd_en),
        .pref_rd_addr_lo (pref_rd_addr_lo),
        .pref_rd_addr_hi (pref_rd_addr_hi),
        .pref_rd_data_lo (pref_rd_data_lo),
        .pref_rd_data_hi (pref_rd_data_hi)
    );

    assign res_take = !out_valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stat.report_valid && res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.report_valid && res_take)
        begin
            out_reg <= res;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.found           = out_reg.found;
    assign results.best_row        = out_reg.best_row;
    assign results.best_column     = out_reg.best_column;
    assign results.best_count      = out_reg.best_count;
    assign results.best_free_count = out_reg.best_free_count;
endmodule
`default_nettype wire

// ===== sv/dwca_checker.sv =====
// Port-level checks of the disk window count argmax unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module dwca_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        in_last,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        found,
    input wire logic [7:0]  best_row,
    input wire logic [7:0]  best_column,
    input wire logic [12:0] best_count,
    input wire logic [12:0] best_free_count
);
    // A final cell starts the scan, so loading stops right after it.
    a_scan_blocks_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_last) |=> !in_ready)
        else $error("cell word accepted right after the final cell");

    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (best_row == 8'd0 && best_column == 8'd0 &&
                                   best_count == 13'd0 && best_free_count == 13'd0))
        else $error("not-found result carries nonzero fields");

    a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (best_count != 13'd0))
        else $error("found result with zero count");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(found) && $stable(best_row) &&
                                      $stable(best_column) && $stable(best_count)))
        else $error("stalled result word changed");
endmodule

bind disk_window_count_argmax_unit dwca_checker u_dwca_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (cells.valid),
    .in_ready        (cells.ready),
    .in_last         (cells.last_cell),
    .out_valid       (results.valid),
    .out_ready       (results.ready),
    .found           (results.found),
    .best_row        (results.best_row),
    .best_column     (results.best_column),
    .best_count      (results.best_count),
    .best_free_count (results.best_free_count)
);
`default_nettype wire
